[sv/stbs_pkg.sv]
// Shared types and constants of the sorted-table binary search block.
package stbs_pkg;

	localparam int IDX_W = 10;
	localparam int DATA_W = 32;
	localparam int TABLE_DEPTH_DEF = 1024;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic action;
		logic [IDX_W-1:0] entry_index;
		logic signed [DATA_W-1:0] entry_value;
		logic signed [DATA_W-1:0] search_key;
		logic [IDX_W-1:0] search_low;
		logic [IDX_W-1:0] search_high;
	} req_t;

	typedef struct packed {
		logic found;
		logic [IDX_W-1:0] match_index;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic start;
		logic probe_first;
		logic probe_next;
		logic post;
		logic post_hit;
	} ctl_cmd_t;

	typedef struct packed {
		logic empty_first;
		logic equal;
		logic empty_next;
	} ctl_sts_t;

endpackage

[sv/sorted_table_binary_search.sv]
// Top level of the sorted-table binary search block.
//
//   Channel  Direction  Payload  Transfer when
//   req      in         req_t    req_valid && !req_stall
//   rsp      out        rsp_t    rsp_valid && !rsp_stall
//
// A load gives no response.
// A search makes P probes, where P is at most IDX_W + 1 (the range may span
// up to 2**IDX_W entries); each probe is one read of the single synchronous
// table read port. An empty starting range gives a not-found response without a probe.
// Reset clears only control state; table entries are undefined until loaded.
// The response waits in an output register; a search that finishes while that
// register is full and stalled holds its state until the transfer completes.
module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	stbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_action(req.action),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts(sts),
		.cmd(cmd)
	);

	stbs_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_datapath (
		.clk(clk),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp)
	);

endmodule

[sv/stbs_datapath.sv]
// Datapath of the binary search: table memory, range registers, probe and result registers.
module stbs_datapath
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic clk,
	input req_t req,
	input ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output rsp_t rsp
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int RW = IDX_W + 2;

	logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

	logic signed [DATA_W-1:0] key_q;
	logic signed [RW-1:0] lo_q;
	logic signed [RW-1:0] hi_q;
	logic [IDX_W-1:0] mid_q;
	logic oor_q;
	logic signed [DATA_W-1:0] rd_q;
	logic found_q;
	logic [IDX_W-1:0] match_q;

	logic signed [RW-1:0] sum_first;
	logic signed [RW-1:0] mid_x;
	logic signed [RW-1:0] mid_inc;
	logic signed [RW-1:0] mid_dec;
	logic signed [RW-1:0] sum_up;
	logic signed [RW-1:0] sum_dn;
	logic signed [DATA_W-1:0] val;
	logic less;
	logic [IDX_W-1:0] probe_addr;
	logic probe;

	always_comb begin
		sum_first = lo_q + hi_q;
		mid_x = $signed({2'b00, mid_q});
		mid_inc = mid_x + RW'(1);
		mid_dec = mid_x - RW'(1);
		sum_up = mid_inc + hi_q;
		sum_dn = lo_q + mid_dec;
		val = oor_q ? '0 : rd_q;
		less = val < key_q;
		sts.empty_first = lo_q > hi_q;
		sts.equal = val == key_q;
		sts.empty_next = less ? (mid_inc > hi_q) : (lo_q > mid_dec);
		probe = cmd.probe_first | cmd.probe_next;
		if (cmd.probe_first) begin
			probe_addr = sum_first[IDX_W:1];
		end else if (less) begin
			probe_addr = sum_up[IDX_W:1];
		end else begin
			probe_addr = sum_dn[IDX_W:1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (32'(req.entry_index) < TABLE_DEPTH)) begin
			mem[AW'(req.entry_index)] <= req.entry_value;
		end
		if (probe) begin
			rd_q <= mem[AW'(probe_addr)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= req.search_key;
			lo_q <= $signed({2'b00, req.search_low});
			hi_q <= $signed({2'b00, req.search_high});
		end else if (cmd.probe_next) begin
			if (less) begin
				lo_q <= mid_inc;
			end else begin
				hi_q <= mid_dec;
			end
		end
		if (probe) begin
			mid_q <= probe_addr;
			oor_q <= 32'(probe_addr) >= TABLE_DEPTH;
		end
		if (cmd.post) begin
			found_q <= cmd.post_hit;
			match_q <= cmd.post_hit ? mid_q : '0;
		end
	end

	assign rsp.found = found_q;
	assign rsp.match_index = match_q;

endmodule

[sv/stbs_ctrl.sv]
// Controller state machine that sequences loads, probes and result transfers.
module stbs_ctrl
	import stbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_action,
	output logic req_stall,
	output logic rsp_valid,
	input logic rsp_stall,
	input ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FIRST = 2'd1;
	localparam logic [1:0] ST_COMP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic rsp_valid_q;
	logic out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_action == ACT_SEARCH) begin
						cmd.start = 1'b1;
						state_d = ST_FIRST;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_FIRST: begin
				if (sts.empty_first) begin
					if (out_free) begin
						cmd.post = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.probe_first = 1'b1;
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (sts.equal || sts.empty_next) begin
					if (out_free) begin
						cmd.post = 1'b1;
						cmd.post_hit = sts.equal;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.post) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
